@@ sv/dqs_pkg.sv @@
package dqs_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int REQ_W      = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [DATA_WIDTH-1:0] data_type;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
   localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd4;
   localparam logic [REQ_W-1:0] REQ_COUNT     = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // one access to the ring memory per cycle of each kind
   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      data_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } ram_req_type;

   // sign-extend the 32-bit request value, then keep DATA_WIDTH bits
   function automatic data_type fit_value(input logic [VALUE_W-1:0] raw);
      logic [63:0] ext;
      ext = {{(64-VALUE_W){raw[VALUE_W-1]}}, raw};
      return ext[DATA_WIDTH-1:0];
   endfunction

   // (front + offset) mod DEPTH, with offset at most DEPTH
   function automatic idx_type ring_add(input idx_type front, input cnt_type offset);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W+1-IDX_W){1'b0}}, front} + {1'b0, offset};
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // (front - 1) mod DEPTH
   function automatic idx_type ring_dec(input idx_type front);
      if (front == '0) begin
         return IDX_W'(DEPTH - 1);
      end
      return front - IDX_W'(1);
   endfunction

endpackage

@@ sv/dqs_ring_ram.sv @@
module dqs_ring_ram
   import dqs_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output data_type    rd_data
);

   data_type mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/deque_with_search_unit.sv @@
// Bounded double-ended queue with linear search, held in a ring memory.
// Results: insert, remove, count and search on an empty queue give a registered result in
// the cycle after the accepting edge; a search ends at its first match or its last entry.
// Throughput: one request per cycle except search, which reads one entry a cycle and holds busy.
// Reset (synchronous): empties the queue, front pointer to zero; entry contents stay undefined.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module deque_with_search_unit
   import dqs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [REQ_W-1:0]           req_type,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [CNT_W-1:0]           rsp_entry_count
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   idx_type               front_ff, front_in;
   cnt_type               occ_ff, occ_in;
   cnt_type               offs_ff, offs_in;
   logic                  pend_ff, pend_in;
   data_type              key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_found_ff, rsp_found_in;

   ram_req_type           ram_req;
   data_type              rd_data;
   data_type              req_fit;
   logic                  is_full;
   logic                  is_empty;
   logic                  hit;

   dqs_ring_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign req_fit  = fit_value(req_value);
   assign is_full  = (occ_ff == CNT_W'(DEPTH));
   assign is_empty = (occ_ff == '0);
   // a read issued last cycle has its data now
   assign hit      = pend_ff && (rd_data == key_ff);

   // Only one request is in flight: the ring is written in idle and read while
   // scanning, so the two never touch the same entry in overlapping cycles.
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      occ_in        = occ_ff;
      offs_in       = offs_ff;
      pend_in       = 1'b0;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      ram_req       = '0;
      ram_req.wr_data = req_fit;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in        = req_fit;
               rsp_status_in = STATUS_OK;
               rsp_found_in  = 1'b0;
               rsp_valid_in  = 1'b1;
               unique case (req_type)
                  REQ_INS_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        front_in        = ring_dec(front_ff);
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = ring_dec(front_ff);
                        occ_in          = occ_ff + CNT_W'(1);
                     end
                  end
                  REQ_INS_BACK: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = ring_add(front_ff, occ_ff);
                        occ_in          = occ_ff + CNT_W'(1);
                     end
                  end
                  REQ_REM_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        front_in = ring_add(front_ff, CNT_W'(1));
                        occ_in   = occ_ff - CNT_W'(1);
                     end
                  end
                  REQ_REM_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        occ_in = occ_ff - CNT_W'(1);
                     end
                  end
                  REQ_SEARCH: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // hold the result back until the scan ends
                        rsp_valid_in = 1'b0;
                        offs_in      = '0;
                        state_in     = S_SCAN;
                     end
                  end
                  default: begin
                     // count request and unused codes: report only
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               // stop at the first match
               rsp_found_in  = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (offs_ff == occ_ff) begin
               // last occupied entry compared, no match
               rsp_found_in  = 1'b0;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               // advance to the next entry from the front
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ring_add(front_ff, offs_ff);
               offs_in         = offs_ff + CNT_W'(1);
               pend_in         = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      offs_ff       <= offs_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign busy            = (state_ff == S_SCAN);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   // the count register already holds the value after the request
   assign rsp_entry_count = occ_ff;

endmodule
